// ----- sv/ped_pkg.sv -----
// ----------------------------------------------------------------------------
// ped_pkg
// Shared widths, types and arithmetic helpers for the polyhedron edge dyad
// pipeline.
// ----------------------------------------------------------------------------
package ped_pkg;

    localparam int COORD_WIDTH      = 21;
    localparam int NORMAL_FRAC_BITS = 16;

    localparam int NORM_W     = 18;
    localparam int VTX_W      = 63;
    localparam int OUT_W      = 19;
    localparam int QUO_W      = NORMAL_FRAC_BITS + 2;
    localparam int UNIT_W     = QUO_W + 1;
    localparam int VEC_W      = NORM_W + UNIT_W + 1;
    localparam int POS_W      = $clog2(VEC_W);
    localparam int MANT_W     = 16;
    localparam int SQRT_GUARD = 14;
    localparam int ROOT_W     = 31;
    localparam int RAD_W      = 2 * ROOT_W + 2;
    localparam int NUM_SHIFT  = NORMAL_FRAC_BITS + SQRT_GUARD;
    localparam int DIV_W      = ROOT_W + QUO_W + 1;
    localparam int DIFF_W     = COORD_WIDTH + 1;
    localparam int DOT_W      = UNIT_W + DIFF_W + 2;
    localparam int ACC_W      = NORM_W + UNIT_W + 1;
    localparam int UNIT_LAT   = 3 + (ROOT_W + 1) + (QUO_W + 1) + 1;

    typedef logic signed [NORM_W-1:0] norm_t;
    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [UNIT_W-1:0] unit_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [OUT_W-1:0]  dyad_t;
    typedef logic [VTX_W-1:0]         vtx_t;

    // one component of a x b: a1*b2 - a2*b1
    function automatic vec_t cross_term(input vec_t a1, input vec_t b2,
                                        input vec_t a2, input vec_t b1);
        vec_t p1;
        vec_t p2;
        p1 = a1 * b2;
        p2 = a2 * b1;
        return p1 - p2;
    endfunction

    // sign-extended coordinate k of a packed vertex
    function automatic diff_t coord(input vtx_t word, input int k);
        logic signed [COORD_WIDTH-1:0] c;
        c = word[k*COORD_WIDTH +: COORD_WIDTH];
        return DIFF_W'(c);
    endfunction

endpackage

// ----- sv/ped_unitize.sv -----
// ----------------------------------------------------------------------------
// ped_unitize
// Pipelined vector normalizer: magnitude scaling, bit-serial square root and
// restoring division, one stage per root or quotient bit.
// ----------------------------------------------------------------------------
module ped_unitize (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  ped_pkg::vec_t  in_vec [3],
    output logic           out_valid,
    output ped_pkg::unit_t out_unit [3],
    output logic           out_zero
);

    localparam int VEC_W  = ped_pkg::VEC_W;
    localparam int POS_W  = ped_pkg::POS_W;
    localparam int MANT_W = ped_pkg::MANT_W;
    localparam int ROOT_W = ped_pkg::ROOT_W;
    localparam int RAD_W  = ped_pkg::RAD_W;
    localparam int QUO_W  = ped_pkg::QUO_W;
    localparam int DIV_W  = ped_pkg::DIV_W;
    localparam int UNIT_W = ped_pkg::UNIT_W;
    localparam int TOP    = MANT_W - 1;

    // stage 0: magnitudes
    logic [VEC_W-1:0] s0_mag_next [3];
    logic [VEC_W-1:0] s0_mag_reg [3];
    logic             s0_neg_reg [3];
    logic             s0_valid_reg;

    // stage 1: leading one
    logic [VEC_W-1:0] s1_any;
    logic [POS_W-1:0] s1_pos_next;
    logic [VEC_W-1:0] s1_mag_reg [3];
    logic             s1_neg_reg [3];
    logic [POS_W-1:0] s1_pos_reg;
    logic             s1_zero_reg;
    logic             s1_valid_reg;

    // stage 2: scaled mantissas
    logic [VEC_W-1:0]  s2_shift [3];
    logic [MANT_W-1:0] s2_mant_next [3];
    logic [MANT_W-1:0] s2_mant_reg [3];
    logic              s2_neg_reg [3];
    logic              s2_zero_reg;
    logic              s2_valid_reg;

    // square root chain
    logic [RAD_W-1:0]  sq_rem_reg   [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root_reg  [ROOT_W+1];
    logic [MANT_W-1:0] sq_mant_reg  [ROOT_W+1][3];
    logic              sq_neg_reg   [ROOT_W+1][3];
    logic              sq_zero_reg  [ROOT_W+1];
    logic              sq_valid_reg [ROOT_W+1];
    logic [RAD_W-1:0]  sq_rem_next;

    // division chain
    logic [DIV_W-1:0]  dv_rem_reg   [QUO_W+1][3];
    logic [QUO_W-1:0]  dv_quo_reg   [QUO_W+1][3];
    logic [ROOT_W-1:0] dv_root_reg  [QUO_W+1];
    logic              dv_neg_reg   [QUO_W+1][3];
    logic              dv_zero_reg  [QUO_W+1];
    logic              dv_valid_reg [QUO_W+1];

    ped_pkg::unit_t out_unit_reg [3];
    logic           out_zero_reg;
    logic           out_valid_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s0_mag_next[k] = in_vec[k][VEC_W-1] ? VEC_W'(-in_vec[k]) : VEC_W'(in_vec[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s0_mag_reg[k] <= s0_mag_next[k];
                s0_neg_reg[k] <= in_vec[k][VEC_W-1];
            end
        end
    end

    assign s1_any = s0_mag_reg[0] | s0_mag_reg[1] | s0_mag_reg[2];

    always_comb
    begin
        s1_pos_next = '0;
        for (int i = 0; i < VEC_W; i++)
        begin
            if (s1_any[i])
            begin
                s1_pos_next = POS_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg  <= s0_mag_reg;
            s1_neg_reg  <= s0_neg_reg;
            s1_pos_reg  <= s1_pos_next;
            s1_zero_reg <= (s1_any == '0);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (s1_pos_reg >= POS_W'(TOP))
            begin
                s2_shift[k] = s1_mag_reg[k] >> (s1_pos_reg - POS_W'(TOP));
            end
            else
            begin
                s2_shift[k] = s1_mag_reg[k] << (POS_W'(TOP) - s1_pos_reg);
            end
            s2_mant_next[k] = s2_shift[k][MANT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_mant_reg <= s2_mant_next;
            s2_neg_reg  <= s1_neg_reg;
            s2_zero_reg <= s1_zero_reg;
        end
    end

    // sum of squares, placed above the guard bits
    always_comb
    begin
        sq_rem_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            sq_rem_next = sq_rem_next + RAD_W'(RAD_W'(s2_mant_reg[k]) * RAD_W'(s2_mant_reg[k]));
        end
        sq_rem_next = sq_rem_next << (2 * ped_pkg::SQRT_GUARD);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rem_reg[0]  <= sq_rem_next;
            sq_root_reg[0] <= '0;
            sq_mant_reg[0] <= s2_mant_reg;
            sq_neg_reg[0]  <= s2_neg_reg;
            sq_zero_reg[0] <= s2_zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg    <= in_valid;
            s1_valid_reg    <= s0_valid_reg;
            s2_valid_reg    <= s1_valid_reg;
            sq_valid_reg[0] <= s2_valid_reg;
        end
    end

    // one root bit per stage, most significant first
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        localparam int B = ROOT_W - 1 - i;
        logic [RAD_W-1:0] trial;
        logic             take;

        assign trial = (RAD_W'(sq_root_reg[i]) << (B + 1)) | (RAD_W'(1) << (2 * B));
        assign take  = (trial <= sq_rem_reg[i]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[i+1]  <= take ? sq_rem_reg[i] - trial : sq_rem_reg[i];
                sq_root_reg[i+1] <= take ? sq_root_reg[i] | (ROOT_W'(1) << B) : sq_root_reg[i];
                sq_mant_reg[i+1] <= sq_mant_reg[i];
                sq_neg_reg[i+1]  <= sq_neg_reg[i];
                sq_zero_reg[i+1] <= sq_zero_reg[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_valid_reg[i+1] <= sq_valid_reg[i];
            end
        end
    end

    // rounded dividend: mantissa scaled up plus half the root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dv_rem_reg[0][k] <= (DIV_W'(sq_mant_reg[ROOT_W][k]) << ped_pkg::NUM_SHIFT)
                                    + DIV_W'(sq_root_reg[ROOT_W] >> 1);
                dv_quo_reg[0][k] <= '0;
            end
            dv_root_reg[0] <= sq_root_reg[ROOT_W];
            dv_neg_reg[0]  <= sq_neg_reg[ROOT_W];
            dv_zero_reg[0] <= sq_zero_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= sq_valid_reg[ROOT_W];
        end
    end

    // one quotient bit per stage for all three lanes
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_div
        localparam int B = QUO_W - 1 - i;
        logic [DIV_W-1:0] dsr;

        assign dsr = DIV_W'(dv_root_reg[i]) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (dv_rem_reg[i][k] >= dsr)
                    begin
                        dv_rem_reg[i+1][k] <= dv_rem_reg[i][k] - dsr;
                        dv_quo_reg[i+1][k] <= dv_quo_reg[i][k] | (QUO_W'(1) << B);
                    end
                    else
                    begin
                        dv_rem_reg[i+1][k] <= dv_rem_reg[i][k];
                        dv_quo_reg[i+1][k] <= dv_quo_reg[i][k];
                    end
                end
                dv_root_reg[i+1] <= dv_root_reg[i];
                dv_neg_reg[i+1]  <= dv_neg_reg[i];
                dv_zero_reg[i+1] <= dv_zero_reg[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                out_unit_reg[k] <= dv_neg_reg[QUO_W][k] ? -UNIT_W'(dv_quo_reg[QUO_W][k])
                                                        : UNIT_W'(dv_quo_reg[QUO_W][k]);
            end
            out_zero_reg <= dv_zero_reg[QUO_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid_reg[QUO_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_unit  = out_unit_reg;
    assign out_zero  = out_zero_reg;

endmodule

// ----- sv/ped_dyad.sv -----
// ----------------------------------------------------------------------------
// ped_dyad
// Orients the edge normals toward the edge and forms the rounded, saturated
// dyad nA*eA^T + nB*eB^T in three stages.
// ----------------------------------------------------------------------------
module ped_dyad (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic           in_zero,
    input  ped_pkg::norm_t na [3],
    input  ped_pkg::norm_t nb [3],
    input  ped_pkg::unit_t ea [3],
    input  ped_pkg::unit_t eb [3],
    input  ped_pkg::diff_t da [3],
    input  ped_pkg::diff_t db [3],
    output logic           out_valid,
    output ped_pkg::dyad_t out_dyad [9],
    output logic           out_degenerate
);

    localparam int DOT_W  = ped_pkg::DOT_W;
    localparam int ACC_W  = ped_pkg::ACC_W;
    localparam int OUT_W  = ped_pkg::OUT_W;
    localparam int NFB    = ped_pkg::NORMAL_FRAC_BITS;
    localparam int HALF   = 1 << (NFB - 1);
    localparam int OUT_LIM = 1 << (OUT_W - 1);

    typedef logic signed [DOT_W-1:0] dot_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    dot_t dot_a;
    dot_t dot_b;

    ped_pkg::norm_t d0_na_reg [3];
    ped_pkg::norm_t d0_nb_reg [3];
    ped_pkg::unit_t d0_ea_reg [3];
    ped_pkg::unit_t d0_eb_reg [3];
    logic           d0_flip_a_reg;
    logic           d0_flip_b_reg;
    logic           d0_zero_reg;
    logic           d0_valid_reg;

    ped_pkg::unit_t fa [3];
    ped_pkg::unit_t fb [3];
    acc_t           d1_pa_reg [9];
    acc_t           d1_pb_reg [9];
    logic           d1_zero_reg;
    logic           d1_valid_reg;

    ped_pkg::dyad_t dyad_next [9];
    ped_pkg::dyad_t dyad_reg [9];
    logic           degenerate_reg;
    logic           valid_reg;

    function automatic ped_pkg::dyad_t round_sat(input acc_t acc);
        logic [ACC_W-1:0] mg;
        logic [ACC_W:0]   r;
        logic             neg;
        neg = acc[ACC_W-1];
        mg  = neg ? ACC_W'(-acc) : ACC_W'(acc);
        r   = ({1'b0, mg} + (ACC_W+1)'(HALF)) >> NFB;
        if (neg)
        begin
            if (r > (ACC_W+1)'(OUT_LIM))
            begin
                r = (ACC_W+1)'(OUT_LIM);
            end
            return ped_pkg::dyad_t'(OUT_W'(0) - r[OUT_W-1:0]);
        end
        else
        begin
            if (r > (ACC_W+1)'(OUT_LIM - 1))
            begin
                r = (ACC_W+1)'(OUT_LIM - 1);
            end
            return ped_pkg::dyad_t'(r[OUT_W-1:0]);
        end
    endfunction

    always_comb
    begin
        dot_a = '0;
        dot_b = '0;
        for (int k = 0; k < 3; k++)
        begin
            dot_a = dot_a + dot_t'(dot_t'(ea[k]) * dot_t'(da[k]));
            dot_b = dot_b + dot_t'(dot_t'(eb[k]) * dot_t'(db[k]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_na_reg     <= na;
            d0_nb_reg     <= nb;
            d0_ea_reg     <= ea;
            d0_eb_reg     <= eb;
            d0_flip_a_reg <= dot_a[DOT_W-1];
            d0_flip_b_reg <= dot_b[DOT_W-1];
            d0_zero_reg   <= in_zero;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fa[k] = d0_flip_a_reg ? -d0_ea_reg[k] : d0_ea_reg[k];
            fb[k] = d0_flip_b_reg ? -d0_eb_reg[k] : d0_eb_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    d1_pa_reg[i*3+j] <= acc_t'(d0_na_reg[i]) * acc_t'(fa[j]);
                    d1_pb_reg[i*3+j] <= acc_t'(d0_nb_reg[i]) * acc_t'(fb[j]);
                end
            end
            d1_zero_reg <= d0_zero_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            dyad_next[k] = d1_zero_reg ? '0 : round_sat(d1_pa_reg[k] + d1_pb_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dyad_reg       <= dyad_next;
            degenerate_reg <= d1_zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_valid_reg <= 1'b0;
            d1_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else if (en)
        begin
            d0_valid_reg <= in_valid;
            d1_valid_reg <= d0_valid_reg;
            valid_reg    <= d1_valid_reg;
        end
    end

    assign out_valid      = valid_reg;
    assign out_dyad       = dyad_reg;
    assign out_degenerate = degenerate_reg;

endmodule

// ----- sv/polyhedron_edge_dyad.sv -----
// ----------------------------------------------------------------------------
// polyhedron_edge_dyad
// Edge dyad of a polyhedron edge from the two facet normals and three
// vertices: edge direction, in-plane edge normals, oriented dyad.
//
//   channel  valid       stall       payload
//   input    edge_valid  edge_stall  normal_a_*, normal_b_*, edge_vertex,
//                                    off_vertex_a, off_vertex_b
//   output   dyad_valid  dyad_stall  dyad_xx .. dyad_zz, degenerate
//
// one edge enters per cycle unless the pipeline holds; the path runs through the
// two chained normalizers (31 square root stages and 18 divide stages each)
// the whole pipeline holds while a result waits under dyad_stall
// rst_n clears only the valid bits; data registers are not reset
// ----------------------------------------------------------------------------
module polyhedron_edge_dyad (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            edge_valid,
    output logic            edge_stall,
    input  ped_pkg::norm_t  normal_a_x,
    input  ped_pkg::norm_t  normal_a_y,
    input  ped_pkg::norm_t  normal_a_z,
    input  ped_pkg::norm_t  normal_b_x,
    input  ped_pkg::norm_t  normal_b_y,
    input  ped_pkg::norm_t  normal_b_z,
    input  ped_pkg::vtx_t   edge_vertex,
    input  ped_pkg::vtx_t   off_vertex_a,
    input  ped_pkg::vtx_t   off_vertex_b,
    output logic            dyad_valid,
    input  logic            dyad_stall,
    output ped_pkg::dyad_t  dyad_xx,
    output ped_pkg::dyad_t  dyad_xy,
    output ped_pkg::dyad_t  dyad_xz,
    output ped_pkg::dyad_t  dyad_yx,
    output ped_pkg::dyad_t  dyad_yy,
    output ped_pkg::dyad_t  dyad_yz,
    output ped_pkg::dyad_t  dyad_zx,
    output ped_pkg::dyad_t  dyad_zy,
    output ped_pkg::dyad_t  dyad_zz,
    output logic            degenerate
);

    localparam int LAT = ped_pkg::UNIT_LAT;

    logic           en;
    ped_pkg::norm_t na_in [3];
    ped_pkg::norm_t nb_in [3];
    ped_pkg::vec_t  va_in [3];
    ped_pkg::vec_t  vb_in [3];

    // cross product of the facet normals
    ped_pkg::vec_t  c1_vec_reg [3];
    ped_pkg::norm_t c1_na_reg [3];
    ped_pkg::norm_t c1_nb_reg [3];
    ped_pkg::diff_t c1_da_reg [3];
    ped_pkg::diff_t c1_db_reg [3];
    logic           c1_valid_reg;

    logic           e_valid;
    ped_pkg::unit_t e_unit [3];
    logic           e_zero;

    ped_pkg::norm_t dl1_na_reg [LAT][3];
    ped_pkg::norm_t dl1_nb_reg [LAT][3];
    ped_pkg::diff_t dl1_da_reg [LAT][3];
    ped_pkg::diff_t dl1_db_reg [LAT][3];

    // edge direction crossed with each normal
    ped_pkg::vec_t  c2_xa_reg [3];
    ped_pkg::vec_t  c2_xb_reg [3];
    ped_pkg::norm_t c2_na_reg [3];
    ped_pkg::norm_t c2_nb_reg [3];
    ped_pkg::diff_t c2_da_reg [3];
    ped_pkg::diff_t c2_db_reg [3];
    logic           c2_zero_reg;
    logic           c2_valid_reg;

    ped_pkg::vec_t  ea_vec [3];
    ped_pkg::vec_t  eb_vec [3];
    ped_pkg::vec_t  na_vec [3];
    ped_pkg::vec_t  nb_vec [3];

    logic           ea_valid;
    logic           eb_valid;
    ped_pkg::unit_t ea_unit [3];
    ped_pkg::unit_t eb_unit [3];
    logic           ea_zero;
    logic           eb_zero;

    ped_pkg::norm_t dl2_na_reg [LAT][3];
    ped_pkg::norm_t dl2_nb_reg [LAT][3];
    ped_pkg::diff_t dl2_da_reg [LAT][3];
    ped_pkg::diff_t dl2_db_reg [LAT][3];
    logic           dl2_zero_reg [LAT];

    ped_pkg::dyad_t dyad [9];

    assign en         = !(dyad_valid && dyad_stall);
    assign edge_stall = !en;

    assign na_in[0] = normal_a_x;
    assign na_in[1] = normal_a_y;
    assign na_in[2] = normal_a_z;
    assign nb_in[0] = normal_b_x;
    assign nb_in[1] = normal_b_y;
    assign nb_in[2] = normal_b_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            va_in[k] = ped_pkg::vec_t'(na_in[k]);
            vb_in[k] = ped_pkg::vec_t'(nb_in[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_vec_reg[0] <= ped_pkg::cross_term(va_in[1], vb_in[2], va_in[2], vb_in[1]);
            c1_vec_reg[1] <= ped_pkg::cross_term(va_in[2], vb_in[0], va_in[0], vb_in[2]);
            c1_vec_reg[2] <= ped_pkg::cross_term(va_in[0], vb_in[1], va_in[1], vb_in[0]);
            c1_na_reg <= na_in;
            c1_nb_reg <= nb_in;
            for (int k = 0; k < 3; k++)
            begin
                c1_da_reg[k] <= ped_pkg::coord(edge_vertex, k)
                                - ped_pkg::coord(off_vertex_a, k);
                c1_db_reg[k] <= ped_pkg::coord(edge_vertex, k)
                                - ped_pkg::coord(off_vertex_b, k);
            end
        end
    end

    ped_unitize u_unit_e (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c1_valid_reg),
        .in_vec    (c1_vec_reg),
        .out_valid (e_valid),
        .out_unit  (e_unit),
        .out_zero  (e_zero)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl1_na_reg[0] <= c1_na_reg;
            dl1_nb_reg[0] <= c1_nb_reg;
            dl1_da_reg[0] <= c1_da_reg;
            dl1_db_reg[0] <= c1_db_reg;
            for (int i = 1; i < LAT; i++)
            begin
                dl1_na_reg[i] <= dl1_na_reg[i-1];
                dl1_nb_reg[i] <= dl1_nb_reg[i-1];
                dl1_da_reg[i] <= dl1_da_reg[i-1];
                dl1_db_reg[i] <= dl1_db_reg[i-1];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ea_vec[k] = ped_pkg::vec_t'(e_unit[k]);
            eb_vec[k] = ped_pkg::vec_t'(e_unit[k]);
            na_vec[k] = ped_pkg::vec_t'(dl1_na_reg[LAT-1][k]);
            nb_vec[k] = ped_pkg::vec_t'(dl1_nb_reg[LAT-1][k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_xa_reg[0] <= ped_pkg::cross_term(ea_vec[1], na_vec[2], ea_vec[2], na_vec[1]);
            c2_xa_reg[1] <= ped_pkg::cross_term(ea_vec[2], na_vec[0], ea_vec[0], na_vec[2]);
            c2_xa_reg[2] <= ped_pkg::cross_term(ea_vec[0], na_vec[1], ea_vec[1], na_vec[0]);
            c2_xb_reg[0] <= ped_pkg::cross_term(eb_vec[1], nb_vec[2], eb_vec[2], nb_vec[1]);
            c2_xb_reg[1] <= ped_pkg::cross_term(eb_vec[2], nb_vec[0], eb_vec[0], nb_vec[2]);
            c2_xb_reg[2] <= ped_pkg::cross_term(eb_vec[0], nb_vec[1], eb_vec[1], nb_vec[0]);
            c2_na_reg   <= dl1_na_reg[LAT-1];
            c2_nb_reg   <= dl1_nb_reg[LAT-1];
            c2_da_reg   <= dl1_da_reg[LAT-1];
            c2_db_reg   <= dl1_db_reg[LAT-1];
            c2_zero_reg <= e_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg <= edge_valid;
            c2_valid_reg <= e_valid;
        end
    end

    ped_unitize u_unit_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c2_valid_reg),
        .in_vec    (c2_xa_reg),
        .out_valid (ea_valid),
        .out_unit  (ea_unit),
        .out_zero  (ea_zero)
    );

    ped_unitize u_unit_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c2_valid_reg),
        .in_vec    (c2_xb_reg),
        .out_valid (eb_valid),
        .out_unit  (eb_unit),
        .out_zero  (eb_zero)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl2_na_reg[0]   <= c2_na_reg;
            dl2_nb_reg[0]   <= c2_nb_reg;
            dl2_da_reg[0]   <= c2_da_reg;
            dl2_db_reg[0]   <= c2_db_reg;
            dl2_zero_reg[0] <= c2_zero_reg;
            for (int i = 1; i < LAT; i++)
            begin
                dl2_na_reg[i]   <= dl2_na_reg[i-1];
                dl2_nb_reg[i]   <= dl2_nb_reg[i-1];
                dl2_da_reg[i]   <= dl2_da_reg[i-1];
                dl2_db_reg[i]   <= dl2_db_reg[i-1];
                dl2_zero_reg[i] <= dl2_zero_reg[i-1];
            end
        end
    end

    ped_dyad u_dyad (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (ea_valid && eb_valid),
        .in_zero        (dl2_zero_reg[LAT-1] || ea_zero || eb_zero),
        .na             (dl2_na_reg[LAT-1]),
        .nb             (dl2_nb_reg[LAT-1]),
        .ea             (ea_unit),
        .eb             (eb_unit),
        .da             (dl2_da_reg[LAT-1]),
        .db             (dl2_db_reg[LAT-1]),
        .out_valid      (dyad_valid),
        .out_dyad       (dyad),
        .out_degenerate (degenerate)
    );

    assign dyad_xx = dyad[0];
    assign dyad_xy = dyad[1];
    assign dyad_xz = dyad[2];
    assign dyad_yx = dyad[3];
    assign dyad_yy = dyad[4];
    assign dyad_yz = dyad[5];
    assign dyad_zx = dyad[6];
    assign dyad_zy = dyad[7];
    assign dyad_zz = dyad[8];

endmodule

// ----- sv/ped_checker.sv -----
// ----------------------------------------------------------------------------
// ped_checker
// Port-level checks of the edge dyad block, bound to its top level.
// ----------------------------------------------------------------------------
module ped_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           edge_valid,
    input logic           edge_stall,
    input ped_pkg::norm_t normal_a_x,
    input ped_pkg::norm_t normal_a_y,
    input ped_pkg::norm_t normal_a_z,
    input ped_pkg::norm_t normal_b_x,
    input ped_pkg::norm_t normal_b_y,
    input ped_pkg::norm_t normal_b_z,
    input ped_pkg::vtx_t  edge_vertex,
    input ped_pkg::vtx_t  off_vertex_a,
    input ped_pkg::vtx_t  off_vertex_b,
    input logic           dyad_valid,
    input logic           dyad_stall,
    input ped_pkg::dyad_t dyad_xx,
    input ped_pkg::dyad_t dyad_xy,
    input ped_pkg::dyad_t dyad_xz,
    input ped_pkg::dyad_t dyad_yx,
    input ped_pkg::dyad_t dyad_yy,
    input ped_pkg::dyad_t dyad_yz,
    input ped_pkg::dyad_t dyad_zx,
    input ped_pkg::dyad_t dyad_zy,
    input ped_pkg::dyad_t dyad_zz,
    input logic           degenerate
);

    // input is held back only by a waiting result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        edge_stall |-> (dyad_valid && dyad_stall))
        else $error("input stalled without a blocked output transfer");

    // degenerate edges carry an all-zero dyad
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dyad_valid && degenerate) |->
            (dyad_xx == '0 && dyad_xy == '0 && dyad_xz == '0 &&
             dyad_yx == '0 && dyad_yy == '0 && dyad_yz == '0 &&
             dyad_zx == '0 && dyad_zy == '0 && dyad_zz == '0))
        else $error("degenerate result with nonzero dyad");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dyad_valid && dyad_stall) |=>
            (dyad_valid && $stable(dyad_xx) && $stable(dyad_yy) &&
             $stable(dyad_zz) && $stable(dyad_xy) && $stable(degenerate)))
        else $error("stalled output transfer changed");

    // the block stays ready while nothing waits at the output
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !dyad_valid |-> !edge_stall)
        else $error("input stalled with empty output");

endmodule

bind polyhedron_edge_dyad ped_checker u_ped_checker (.*);
